FILE: src/light_tamper_detector_core_defines.svh
// Assertion macros for the light tamper detector core.
`ifndef LIGHT_TAMPER_DETECTOR_CORE_DEFINES_SVH
`define LIGHT_TAMPER_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, idle during reset.
`define LTD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, idle during reset.
`define LTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ltd_pkg.sv
// Shared types and constants of the light tamper detector core.
package ltd_pkg;

    localparam int unsigned THRESH_W  = 12;
    localparam int unsigned REF_OUT_W = 13;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd200;

    typedef enum logic {
        ACTION_CALIBRATE = 1'b0,
        ACTION_SAMPLE    = 1'b1
    } action_t;

    typedef logic [THRESH_W-1:0] thresh_t;

endpackage

FILE: src/light_tamper_detector_core.sv
// Light tamper detector: calibration, anomaly check and tamper run detection.
//
// Usage:
//   Input channel (s_valid/s_ready): s_action = 0 starts a calibration,
//   s_action = 1 carries a light reading in s_sample.
//   Result channel (m_valid/m_ready): one transfer per input transfer with
//   m_anomaly, m_tamper, m_calibration_done and m_reference_level.
//   Config channel (cfg_valid/cfg_ready): cfg_data sets the anomaly threshold;
//   write only while the block is idle. cfg_ready is always high.
// Timing: the result is registered and becomes valid in the cycle after the input transfer.
// Throughput: one item per cycle while no result is held back by m_ready; the state update, the mean of the window
//   (one reciprocal multiply), the distance compare and the history shift
//   all sit between the input handshake and the result register.
// Reset: threshold returns to 200, reference to -1, window and history empty,
//   result register empty.
// Stall: while a result is held and m_ready is low the result register holds and s_ready drops;
//   a new item is taken in the same cycle the held result is transferred.
`include "light_tamper_detector_core_defines.svh"

module light_tamper_detector_core #(
    parameter int unsigned WINDOW      = 8,
    parameter int unsigned RUN         = 8,
    parameter int unsigned SAMPLE_BITS = 12
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ltd_pkg::THRESH_W-1:0]         cfg_data,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_action,
    input  logic [SAMPLE_BITS-1:0]               s_sample,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_anomaly,
    output logic                                 m_tamper,
    output logic                                 m_calibration_done,
    output logic signed [ltd_pkg::REF_OUT_W-1:0] m_reference_level
);

    localparam int unsigned FILL_W    = $clog2(WINDOW + 1);
    localparam int unsigned SUM_W     = SAMPLE_BITS + $clog2(WINDOW);
    localparam int unsigned DIV_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int unsigned MULT_W    = SUM_W + 2;
    localparam int unsigned PROD_W    = SUM_W + MULT_W;
    localparam longint unsigned DIV_MULT =
        ((longint'(1) << DIV_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);
    localparam int unsigned REF_W     = SAMPLE_BITS + 1;
    localparam int unsigned DIFF_W    = SAMPLE_BITS + 2;
    localparam int unsigned ABS_W     = SAMPLE_BITS + 1;
    localparam int unsigned CMP_W     =
        (ABS_W > ltd_pkg::THRESH_W) ? ABS_W : ltd_pkg::THRESH_W;
    localparam int unsigned EXT_W     =
        (REF_W > ltd_pkg::REF_OUT_W) ? REF_W : ltd_pkg::REF_OUT_W;

    ltd_pkg::thresh_t          thresh_reg;
    logic                      calibrating_reg, calibrating_next;
    logic [FILL_W-1:0]         fill_count_reg, fill_count_next;
    logic [SUM_W-1:0]          calib_sum_reg, calib_sum_next;
    logic signed [REF_W-1:0]   reference_reg, reference_next;
    logic [RUN-1:0]            history_reg, history_next;

    logic                      m_valid_reg;
    logic                      anomaly_reg, anomaly_next;
    logic                      tamper_reg, tamper_next;
    logic                      done_reg, done_next;

    logic                      in_xfer;
    logic [SUM_W-1:0]          sum_inc;
    logic [PROD_W-1:0]         prod;
    logic [PROD_W-1:0]         prod_shift;
    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]         diff_abs;
    logic                      over;
    logic [RUN:0]              hist_shift;
    logic signed [EXT_W-1:0]   ref_ext;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_xfer   = s_valid && s_ready;

    assign sum_inc    = calib_sum_reg + SUM_W'(s_sample);
    assign prod       = PROD_W'(sum_inc) * PROD_W'(DIV_MULT);
    assign prod_shift = prod >> DIV_SHIFT;

    assign diff     = DIFF_W'($signed({1'b0, s_sample})) - DIFF_W'(reference_reg);
    assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign over     = CMP_W'(diff_abs[ABS_W-1:0]) > CMP_W'(thresh_reg);
    assign hist_shift = {history_reg, over};

    always_comb begin
        calibrating_next = calibrating_reg;
        fill_count_next  = fill_count_reg;
        calib_sum_next   = calib_sum_reg;
        reference_next   = reference_reg;
        history_next     = history_reg;
        anomaly_next     = 1'b0;
        tamper_next      = 1'b0;
        done_next        = 1'b0;
        if (s_action == ltd_pkg::ACTION_CALIBRATE) begin
            calibrating_next = 1'b1;
            calib_sum_next   = '0;
            fill_count_next  = '0;
            history_next     = '0;
        end else if (calibrating_reg) begin
            calib_sum_next  = sum_inc;
            fill_count_next = fill_count_reg + FILL_W'(1);
            if (fill_count_reg >= FILL_W'(WINDOW - 1)) begin
                reference_next   = REF_W'($signed({1'b0, prod_shift[SAMPLE_BITS-1:0]}));
                fill_count_next  = FILL_W'(WINDOW);
                calibrating_next = 1'b0;
                calib_sum_next   = '0;
                done_next        = 1'b1;
            end
        end else if (fill_count_reg < FILL_W'(WINDOW)) begin
            fill_count_next = fill_count_reg + FILL_W'(1);
        end else begin
            anomaly_next = over;
            history_next = hist_shift[RUN-1:0];
            tamper_next  = &hist_shift[RUN-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg      <= ltd_pkg::THRESH_RESET;
            calibrating_reg <= 1'b0;
            fill_count_reg  <= '0;
            calib_sum_reg   <= '0;
            reference_reg   <= '1;
            history_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                thresh_reg <= cfg_data;
            end
            if (in_xfer) begin
                calibrating_reg <= calibrating_next;
                fill_count_reg  <= fill_count_next;
                calib_sum_reg   <= calib_sum_next;
                reference_reg   <= reference_next;
                history_reg     <= history_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            anomaly_reg <= anomaly_next;
            tamper_reg  <= tamper_next;
            done_reg    <= done_next;
        end
    end

    assign ref_ext = EXT_W'(reference_reg);

    assign m_valid            = m_valid_reg;
    assign m_anomaly          = anomaly_reg;
    assign m_tamper           = tamper_reg;
    assign m_calibration_done = done_reg;
    assign m_reference_level  = ref_ext[ltd_pkg::REF_OUT_W-1:0];

    `LTD_ASSERT_NEXT(a_cal_restart,
        in_xfer && (s_action == ltd_pkg::ACTION_CALIBRATE),
        calibrating_reg && (fill_count_reg == '0) && (history_reg == '0),
        "calibration command did not clear window and history")
    `LTD_ASSERT_NOW(a_done_quiet, m_valid_reg && done_reg,
        !anomaly_reg && !tamper_reg && !calibrating_reg,
        "calibration result carries a check flag")
    `LTD_ASSERT_NOW(a_tamper_flag, m_valid_reg && tamper_reg, anomaly_reg,
        "tamper without anomaly on the same result")
    `LTD_ASSERT_NOW(a_fill_bound, 1'b1, fill_count_reg <= FILL_W'(WINDOW),
        "window fill level beyond window size")

endmodule
